### design/tkcl_pkg.sv
// Package with shared constants, codes and types of the top-k count list.
`default_nettype none
package tkcl_pkg;

	localparam int TOP_DEPTH = 8;
	localparam int IDX_W     = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
	localparam int FILL_W    = $clog2(TOP_DEPTH + 1);
	// Wide enough for any index or fill value over the whole depth range.
	localparam int EXT_W     = 8;

	localparam int KEY_W    = 48;
	localparam int COUNT_W  = 32;
	localparam int POS_W    = 3;
	localparam int STATUS_W = 3;
	localparam int LEVEL_W  = 4;

	localparam logic REQ_OFFER = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PRESENT  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REPLACED = 3'd2,
		ST_REJECTED = 3'd3,
		ST_READ_OK  = 3'd4,
		ST_READ_EMP = 3'd5
	} status_t;

	// Broadcast from the control to every cell of the row.
	typedef struct packed {
		logic               ins;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} bcast_t;

endpackage
`default_nettype wire

### design/top_k_count_list.sv
// Top level of the top-k count list: control, result register and the cell row.
//
//   channel | signals                                        | dir
//   input   | in_valid in_ready req_type offer_key offer_count read_index | in
//   output  | out_valid out_ready status position entry_key entry_count fill_level | out
//
// Every request is handled in the cycle it is accepted; its result is registered
// and shows in the next cycle, so a request can be taken every cycle unless a result waits for out_ready.
// The key compare and count compare run in all cells at once; the row shifts in one step.
// A result waiting for out_ready holds in_ready low only while the register is full.
// Reset clears the fill count and the result valid; stored entries and result fields need no reset.
`default_nettype none
module top_k_count_list (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic [tkcl_pkg::KEY_W-1:0]        offer_key,
	input  wire logic [tkcl_pkg::COUNT_W-1:0]      offer_count,
	input  wire logic [tkcl_pkg::POS_W-1:0]        read_index,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [tkcl_pkg::STATUS_W-1:0]     status,
	output logic      [tkcl_pkg::POS_W-1:0]        position,
	output logic      [tkcl_pkg::KEY_W-1:0]        entry_key,
	output logic      [tkcl_pkg::COUNT_W-1:0]      entry_count,
	output logic      [tkcl_pkg::LEVEL_W-1:0]      fill_level
);

	logic                                 out_valid_q;
	logic [tkcl_pkg::FILL_W-1:0]          fill_q;
	logic [tkcl_pkg::STATUS_W-1:0]        status_q;
	logic [tkcl_pkg::POS_W-1:0]           position_q;
	logic [tkcl_pkg::KEY_W-1:0]           entry_key_q;
	logic [tkcl_pkg::COUNT_W-1:0]         entry_count_q;
	logic [tkcl_pkg::LEVEL_W-1:0]         fill_level_q;

	logic                                 accept;
	logic                                 full;
	logic                                 found;
	tkcl_pkg::bcast_t                     bcast;
	tkcl_pkg::status_t                    status_nxt;
	logic [tkcl_pkg::FILL_W-1:0]          fill_nxt;
	logic [tkcl_pkg::IDX_W-1:0]           match_pos;
	logic [tkcl_pkg::IDX_W-1:0]           ins_pos;
	logic [tkcl_pkg::EXT_W-1:0]           pos_ext;
	logic [tkcl_pkg::EXT_W-1:0]           ridx_ext;
	logic [tkcl_pkg::KEY_W-1:0]           rd_key;
	logic [tkcl_pkg::COUNT_W-1:0]         rd_count;

	logic [tkcl_pkg::TOP_DEPTH-1:0]       valid_vec;
	logic [tkcl_pkg::TOP_DEPTH-1:0]       ge_vec;
	logic [tkcl_pkg::TOP_DEPTH-1:0]       match_vec;
	logic [tkcl_pkg::TOP_DEPTH-1:0]       first_vec;
	logic [tkcl_pkg::KEY_W-1:0]           cell_key   [tkcl_pkg::TOP_DEPTH];
	logic [tkcl_pkg::COUNT_W-1:0]         cell_count [tkcl_pkg::TOP_DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (fill_q == tkcl_pkg::FILL_W'(tkcl_pkg::TOP_DEPTH));
	assign found    = |match_vec;

	for (genvar i = 0; i < tkcl_pkg::TOP_DEPTH; i++) begin : g_cell
		assign valid_vec[i] = (tkcl_pkg::EXT_W'(i) < tkcl_pkg::EXT_W'(fill_q));
		if (i == 0) begin : g_head
			tkcl_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.valid      (valid_vec[i]),
				.ge_left    (1'b1),
				.key_left   (bcast.key),
				.count_left (bcast.count),
				.key        (cell_key[i]),
				.count      (cell_count[i]),
				.ge         (ge_vec[i]),
				.match      (match_vec[i]),
				.first      (first_vec[i])
			);
		end else begin : g_body
			tkcl_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.valid      (valid_vec[i]),
				.ge_left    (ge_vec[i-1]),
				.key_left   (cell_key[i-1]),
				.count_left (cell_count[i-1]),
				.key        (cell_key[i]),
				.count      (cell_count[i]),
				.ge         (ge_vec[i]),
				.match      (match_vec[i]),
				.first      (first_vec[i])
			);
		end
	end

	// Keys in the list are unique and the counts are sorted, so both vectors
	// are one-hot at most and an OR of the indexes encodes them.
	always_comb begin
		match_pos = '0;
		ins_pos   = '0;
		rd_key    = '0;
		rd_count  = '0;
		ridx_ext  = tkcl_pkg::EXT_W'(read_index);
		for (int i = 0; i < tkcl_pkg::TOP_DEPTH; i++) begin
			if (match_vec[i]) begin
				match_pos = match_pos | tkcl_pkg::IDX_W'(i);
			end
			if (first_vec[i]) begin
				ins_pos = ins_pos | tkcl_pkg::IDX_W'(i);
			end
			if (ridx_ext == tkcl_pkg::EXT_W'(i)) begin
				rd_key   = cell_key[i];
				rd_count = cell_count[i];
			end
		end
	end

	always_comb begin
		bcast.key   = offer_key;
		bcast.count = offer_count;
		bcast.ins   = 1'b0;
		fill_nxt    = fill_q;
		pos_ext     = '0;
		if (req_type == tkcl_pkg::REQ_READ) begin
			pos_ext = ridx_ext;
			if (ridx_ext < tkcl_pkg::EXT_W'(fill_q)) begin
				status_nxt = tkcl_pkg::ST_READ_OK;
			end else begin
				status_nxt = tkcl_pkg::ST_READ_EMP;
			end
		end else if (found) begin
			status_nxt = tkcl_pkg::ST_PRESENT;
			pos_ext    = tkcl_pkg::EXT_W'(match_pos);
		end else if (!full) begin
			status_nxt = tkcl_pkg::ST_INSERTED;
			pos_ext    = tkcl_pkg::EXT_W'(ins_pos);
			bcast.ins  = accept;
			fill_nxt   = fill_q + tkcl_pkg::FILL_W'(1);
		end else if (!ge_vec[tkcl_pkg::TOP_DEPTH-1]) begin
			// The offer beats the last entry, which drops off the end of the row.
			status_nxt = tkcl_pkg::ST_REPLACED;
			pos_ext    = tkcl_pkg::EXT_W'(ins_pos);
			bcast.ins  = accept;
		end else begin
			status_nxt = tkcl_pkg::ST_REJECTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				fill_q      <= fill_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_nxt;
			position_q   <= pos_ext[tkcl_pkg::POS_W-1:0];
			fill_level_q <= tkcl_pkg::LEVEL_W'(tkcl_pkg::EXT_W'(fill_nxt));
			if (status_nxt == tkcl_pkg::ST_READ_OK) begin
				entry_key_q   <= rd_key;
				entry_count_q <= rd_count;
			end else begin
				entry_key_q   <= '0;
				entry_count_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_key   = entry_key_q;
	assign entry_count = entry_count_q;
	assign fill_level  = fill_level_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tkcl_pkg::FILL_W'(tkcl_pkg::TOP_DEPTH))
		else $error("fill level beyond list depth");

	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("offered key matches more than one entry");

	a_sorted_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("list counts are not in descending order");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (|first_vec))
		else $error("no insert place while a slot is free");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_nxt == tkcl_pkg::ST_INSERTED |=>
		fill_q == $past(fill_q) + tkcl_pkg::FILL_W'(1))
		else $error("insert into a free slot did not grow the list");

endmodule
`default_nettype wire

### design/tkcl_cell.sv
// One list cell: holds an entry, compares it with the offer, shifts or loads.
`default_nettype none
module tkcl_cell (
	input  wire logic                            clk,
	input  wire tkcl_pkg::bcast_t                bcast,
	input  wire logic                            valid,
	input  wire logic                            ge_left,
	input  wire logic [tkcl_pkg::KEY_W-1:0]      key_left,
	input  wire logic [tkcl_pkg::COUNT_W-1:0]    count_left,
	output logic      [tkcl_pkg::KEY_W-1:0]      key,
	output logic      [tkcl_pkg::COUNT_W-1:0]    count,
	output logic                                 ge,
	output logic                                 match,
	output logic                                 first
);

	logic [tkcl_pkg::KEY_W-1:0]   key_q;
	logic [tkcl_pkg::COUNT_W-1:0] count_q;

	assign ge    = valid && (count_q >= bcast.count);
	assign match = valid && (key_q == bcast.key);
	// The first cell whose entry sorts after the offer takes the new entry.
	assign first = ge_left && !ge;

	always_ff @(posedge clk) begin
		if (bcast.ins && first) begin
			key_q   <= bcast.key;
			count_q <= bcast.count;
		end else if (bcast.ins && !ge_left) begin
			key_q   <= key_left;
			count_q <= count_left;
		end
	end

	assign key   = key_q;
	assign count = count_q;

endmodule
`default_nettype wire
